// File: design/knn_pkg.sv
`default_nettype none
package knn_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int PT_AW       = $clog2(MAX_POINTS);
  localparam int CNT_W       = PT_AW + 1;
  localparam int MAX_CLASSES = 256;
  localparam int CLS_AW      = $clog2(MAX_CLASSES);
  localparam int LABEL_W     = 8;
  localparam int COORD_BITS  = 16;
  localparam int SQ_W        = 2 * COORD_BITS;
  localparam int DIST_W      = SQ_W + 1;
  localparam int K_W         = 11;
  localparam int ADDR_W      = 3;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic REG_NEIGHBOUR_COUNT = 1'b0;

  typedef struct packed {
    logic [LABEL_W-1:0]    cls;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } point_t;

  typedef struct packed {
    logic [LABEL_W-1:0] cls;
    logic [DIST_W-1:0]  dsq;
  } dist_entry_t;

endpackage
`default_nettype wire

// File: design/knn_sq_unit.sv
`default_nettype none
module knn_sq_unit (
  input  wire logic                                  clk,
  input  wire logic signed [knn_pkg::COORD_BITS-1:0] a,
  input  wire logic signed [knn_pkg::COORD_BITS-1:0] b,
  output logic [knn_pkg::SQ_W-1:0]                   q
);
  import knn_pkg::*;

  logic signed [COORD_BITS:0] diff;
  logic        [COORD_BITS:0] mag;
  logic        [SQ_W-1:0]     mag_ext;

  assign diff    = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  assign mag     = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
  assign mag_ext = SQ_W'(mag[COORD_BITS-1:0]);

  always_ff @(posedge clk) begin
    q <= SQ_W'(mag_ext * mag_ext);
  end

endmodule
`default_nettype wire

// File: design/knn_majority_classifier.sv
// Channel   Ports                                        Handshake
// request   req_type class_label coord_x coord_y         start && !busy
// result    winning_class winning_votes neighbours_used  done, one cycle
// config    psel penable pwrite paddr pwdata prdata      APB, pready tied high
//
// Clear and add requests never raise busy.
// A query keeps busy high while distances go through the one squaring unit, then a
// bisection over the 33-bit distance range counts points per pass, then votes and a
// label scan.
// Reset is synchronous and empties the store; the receiver cannot stall.
`default_nettype none
module knn_majority_classifier (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        req_type,
  input  wire logic [knn_pkg::LABEL_W-1:0]       class_label,
  input  wire logic signed [15:0]                coord_x,
  input  wire logic signed [15:0]                coord_y,
  output logic                                   done,
  output logic [knn_pkg::LABEL_W-1:0]            winning_class,
  output logic [knn_pkg::K_W-1:0]                winning_votes,
  output logic [knn_pkg::K_W-1:0]                neighbours_used,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [knn_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import knn_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DRD   = 13'b0000000000010,
    S_DSQX  = 13'b0000000000100,
    S_DSQY  = 13'b0000000001000,
    S_DWR   = 13'b0000000010000,
    S_BS    = 13'b0000000100000,
    S_BSEND = 13'b0000001000000,
    S_VCLR  = 13'b0000010000000,
    S_VRD   = 13'b0000100000000,
    S_VCHK  = 13'b0001000000000,
    S_VINC  = 13'b0010000000000,
    S_MAX   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state;

  point_t      point_mem [MAX_POINTS];
  dist_entry_t dist_mem  [MAX_POINTS];
  logic [K_W-1:0] vote_mem [MAX_CLASSES];

  logic [K_W-1:0]        neighbour_count;
  logic [CNT_W-1:0]      point_total;
  logic signed [COORD_BITS-1:0] qx, qy;
  logic [CNT_W-1:0]      idx, ri, cnt, used;
  logic [DIST_W-1:0]     lo, hi, kth;
  logic [SQ_W-1:0]       sqx;
  logic                  dv;
  logic [CLS_AW-1:0]     vi, scls;
  logic [CLS_AW:0]       si;
  logic                  sv;
  logic [LABEL_W-1:0]    best_class;
  logic [K_W-1:0]        best_votes;

  point_t      pt_q;
  dist_entry_t dq;
  logic [K_W-1:0] vq;

  logic signed [COORD_BITS-1:0] sq_a, sq_b;
  logic [SQ_W-1:0]   sq_q;
  logic [DIST_W-1:0] mid, mid_inc, dist_sum;
  logic [K_W-1:0]    k_raw, k_eff;
  logic [PT_AW-1:0]  dist_ra;
  logic [CLS_AW-1:0] vote_ra, vote_wa;
  logic [K_W-1:0]    vote_wd;
  logic              vote_we;
  logic              bs_issue, mx_issue, last_pt, accept;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_NEIGHBOUR_COUNT) ? 32'(neighbour_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbour_count <= K_W'(1);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_NEIGHBOUR_COUNT) begin
      neighbour_count <= pwdata[K_W-1:0];
    end
  end

  // A register value of zero behaves as one, and k never exceeds the point count.
  assign k_raw = (neighbour_count == '0) ? K_W'(1) : neighbour_count;
  assign k_eff = (k_raw > K_W'(point_total)) ? K_W'(point_total) : k_raw;

  assign mid      = DIST_W'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign mid_inc  = mid + 1'b1;
  assign dist_sum = DIST_W'(sqx) + DIST_W'(sq_q);
  assign bs_issue = (ri < point_total);
  assign mx_issue = (si < (CLS_AW+1)'(MAX_CLASSES));
  assign last_pt  = ((idx + 1'b1) == point_total);

  always_comb begin
    if (state == S_DSQY) begin
      sq_a = signed'(pt_q.y);
      sq_b = qy;
    end else begin
      sq_a = signed'(pt_q.x);
      sq_b = qx;
    end
  end

  knn_sq_unit u_sq (
    .clk (clk),
    .a   (sq_a),
    .b   (sq_b),
    .q   (sq_q)
  );

  assign dist_ra = (state == S_BS) ? ri[PT_AW-1:0] : idx[PT_AW-1:0];
  assign vote_ra = (state == S_MAX) ? si[CLS_AW-1:0] : dq.cls[CLS_AW-1:0];

  always_comb begin
    vote_we = 1'b0;
    vote_wa = vi;
    vote_wd = '0;
    if (state == S_VCLR) begin
      vote_we = 1'b1;
    end else if (state == S_VINC) begin
      vote_we = 1'b1;
      vote_wa = dq.cls[CLS_AW-1:0];
      vote_wd = vq + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && req_type == REQ_ADD &&
        point_total < CNT_W'(MAX_POINTS)) begin
      point_mem[point_total[PT_AW-1:0]] <= '{cls: class_label,
                                             y: coord_y[COORD_BITS-1:0],
                                             x: coord_x[COORD_BITS-1:0]};
    end
    pt_q <= point_mem[idx[PT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_DWR) begin
      dist_mem[idx[PT_AW-1:0]] <= '{cls: pt_q.cls, dsq: dist_sum};
    end
    dq <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk) begin
    if (vote_we) begin
      vote_mem[vote_wa] <= vote_wd;
    end
    vq <= vote_mem[vote_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_total <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req_type == REQ_CLEAR) begin
              point_total <= '0;
            end else if (req_type == REQ_ADD) begin
              if (point_total < CNT_W'(MAX_POINTS)) begin
                point_total <= point_total + 1'b1;
              end
            end else if (req_type == REQ_QUERY) begin
              qx  <= coord_x[COORD_BITS-1:0];
              qy  <= coord_y[COORD_BITS-1:0];
              idx <= '0;
              if (point_total == '0) begin
                best_class <= LABEL_W'(1);
                best_votes <= '0;
                used       <= '0;
                state      <= S_DONE;
              end else begin
                state <= S_DRD;
              end
            end
          end
        end
        S_DRD:  state <= S_DSQX;
        S_DSQX: state <= S_DSQY;
        S_DSQY: begin
          sqx   <= sq_q;
          state <= S_DWR;
        end
        S_DWR: begin
          if (last_pt) begin
            ri    <= '0;
            cnt   <= '0;
            dv    <= 1'b0;
            lo    <= '0;
            hi    <= '1;
            state <= S_BS;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_DRD;
          end
        end
        S_BS: begin
          if (bs_issue) begin
            ri <= ri + 1'b1;
          end
          dv <= bs_issue;
          if (dv && dq.dsq <= mid) begin
            cnt <= cnt + 1'b1;
          end
          if (!bs_issue && !dv) begin
            state <= S_BSEND;
          end
        end
        S_BSEND: begin
          // Bisection for the least distance that at least k points reach.
          ri  <= '0;
          cnt <= '0;
          if (K_W'(cnt) >= k_eff) begin
            hi <= mid;
            if (mid == lo) begin
              kth   <= mid;
              vi    <= '0;
              state <= S_VCLR;
            end else begin
              state <= S_BS;
            end
          end else begin
            lo <= mid_inc;
            if (mid_inc == hi) begin
              kth   <= hi;
              vi    <= '0;
              state <= S_VCLR;
            end else begin
              state <= S_BS;
            end
          end
        end
        S_VCLR: begin
          vi <= vi + 1'b1;
          if (vi == '1) begin
            idx   <= '0;
            used  <= '0;
            state <= S_VRD;
          end
        end
        S_VRD: state <= S_VCHK;
        S_VCHK, S_VINC: begin
          if (state == S_VCHK && dq.dsq <= kth) begin
            used  <= used + 1'b1;
            state <= S_VINC;
          end else if (last_pt) begin
            si         <= (CLS_AW+1)'(1);
            sv         <= 1'b0;
            best_class <= LABEL_W'(1);
            best_votes <= '0;
            state      <= S_MAX;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_VRD;
          end
        end
        S_MAX: begin
          if (mx_issue) begin
            si <= si + 1'b1;
          end
          sv   <= mx_issue;
          scls <= si[CLS_AW-1:0];
          if (sv && vq > best_votes) begin
            best_votes <= vq;
            best_class <= LABEL_W'(scls);
          end
          if (!mx_issue && !sv) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          done            <= 1'b1;
          winning_class   <= best_class;
          winning_votes   <= best_votes;
          neighbours_used <= K_W'(used);
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/knn_checker.sv
`default_nettype none
module knn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  req_type,
  input wire logic        done,
  input wire logic [7:0]  winning_class,
  input wire logic [10:0] winning_votes,
  input wire logic [10:0] neighbours_used
);
  import knn_pkg::*;

  // A result is only shown once the sequencer is back in idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_votes_le_used: assert property (@(posedge clk) disable iff (rst)
    done |-> winning_votes <= neighbours_used)
    else $error("winning votes exceed neighbours used");

  a_class_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> winning_class != 8'd0)
    else $error("label zero reported as winner");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_QUERY) |=> busy)
    else $error("query request did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

bind knn_majority_classifier knn_checker u_knn_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .req_type        (req_type),
  .done            (done),
  .winning_class   (winning_class),
  .winning_votes   (winning_votes),
  .neighbours_used (neighbours_used)
);
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
  import knn_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = REQ_CLEAR;
  logic [LABEL_W-1:0] class_label = '0;
  logic signed [15:0] coord_x = '0;
  logic signed [15:0] coord_y = '0;
  logic done;
  logic [LABEL_W-1:0] winning_class;
  logic [K_W-1:0] winning_votes;
  logic [K_W-1:0] neighbours_used;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 400000;

  typedef struct packed {
    logic [LABEL_W-1:0] cls;
    logic [K_W-1:0] votes;
    logic [K_W-1:0] used;
  } vote_t;

  knn_majority_classifier dut (.*);

  always #1 clk = ~clk;

  // Shadow store of the block.
  logic signed [15:0] shadow_x [MAX_POINTS];
  logic signed [15:0] shadow_y [MAX_POINTS];
  logic [LABEL_W-1:0] shadow_cls [MAX_POINTS];
  int shadow_total;
  int shadow_k;
  vote_t pending_votes [$];
  int errors;
  int quiet_cycles;

  function automatic vote_t classify(logic signed [15:0] qx, logic signed [15:0] qy);
    longint unsigned dsq [];
    longint unsigned kth;
    longint signed dx, dy;
    int votes [MAX_CLASSES];
    int n, k, cnt, used, best, best_votes;
    bit found;
    vote_t r;
    n = shadow_total;
    if (n == 0) begin
      r.cls = 8'd1;
      r.votes = '0;
      r.used = '0;
      return r;
    end
    k = (shadow_k < 1) ? 1 : shadow_k;
    if (k > n) k = n;
    dsq = new[n];
    for (int i = 0; i < n; i++) begin
      dx = longint'(shadow_x[i]) - longint'(qx);
      dy = longint'(shadow_y[i]) - longint'(qy);
      dsq[i] = dx * dx + dy * dy;
    end
    kth = 0;
    found = 0;
    for (int i = 0; i < n; i++) begin
      cnt = 0;
      for (int j = 0; j < n; j++)
        if (dsq[j] <= dsq[i]) cnt++;
      if (cnt >= k && (!found || dsq[i] < kth)) begin
        kth = dsq[i];
        found = 1;
      end
    end
    foreach (votes[c]) votes[c] = 0;
    used = 0;
    for (int i = 0; i < n; i++) begin
      if (dsq[i] <= kth) begin
        votes[shadow_cls[i]]++;
        used++;
      end
    end
    best = 1;
    best_votes = votes[1];
    for (int c = 1; c < MAX_CLASSES; c++) begin
      if (votes[c] > best_votes) begin
        best_votes = votes[c];
        best = c;
      end
    end
    r.cls = best[LABEL_W-1:0];
    r.votes = best_votes[K_W-1:0];
    r.used = used[K_W-1:0];
    return r;
  endfunction

  // Sends one request and updates the shadow store once it is accepted.
  task automatic send_request(logic [1:0] kind, logic [7:0] lbl,
                              logic signed [15:0] x, logic signed [15:0] y);
    start <= 1'b1;
    req_type <= kind;
    class_label <= lbl;
    coord_x <= x;
    coord_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (kind)
      REQ_CLEAR: shadow_total = 0;
      REQ_ADD: begin
        if (shadow_total < MAX_POINTS) begin
          shadow_x[shadow_total] = x;
          shadow_y[shadow_total] = y;
          shadow_cls[shadow_total] = lbl;
          shadow_total++;
        end
      end
      REQ_QUERY: begin
        pending_votes.push_back(classify(x, y));
      end
      default: ;
    endcase
    // Random gaps between bursts of requests.
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_votes.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_k(int value);
    go_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * REG_NEIGHBOUR_COUNT);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_k = value & 32'h7FF;
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  task automatic test_directed();
    send_request(REQ_QUERY, 8'd5, 16'sd0, 16'sd0);
    send_request(REQ_UNUSED, 8'd9, 16'sd3, 16'sd3);
    send_request(REQ_ADD, 8'd255, 16'sh7FFF, 16'sh7FFF);
    send_request(REQ_ADD, 8'd0, 16'sh8000, 16'sh8000);
    send_request(REQ_ADD, 8'd1, 16'sh7FFF, 16'sh8000);
    send_request(REQ_QUERY, 8'd0, 16'sh8000, 16'sh7FFF);
    send_request(REQ_QUERY, 8'd0, 16'sh7FFF, 16'sh7FFF);
    send_request(REQ_QUERY, 8'd0, 16'sh8000, 16'sh8000);
    send_request(REQ_CLEAR, 8'd0, 16'sd0, 16'sd0);
    // Ties at the k-th distance: four points on a ring around the origin.
    send_request(REQ_ADD, 8'd3, 16'sd1, 16'sd0);
    send_request(REQ_ADD, 8'd2, -16'sd1, 16'sd0);
    send_request(REQ_ADD, 8'd2, 16'sd0, 16'sd1);
    send_request(REQ_ADD, 8'd3, 16'sd0, -16'sd1);
    send_request(REQ_ADD, 8'd0, 16'sd9, 16'sd9);
    send_request(REQ_QUERY, 8'd0, 16'sd0, 16'sd0);
    send_request(REQ_QUERY, 8'd0, 16'sd9, 16'sd9);
    write_k(0);
    send_request(REQ_QUERY, 8'd0, 16'sd0, 16'sd0);
    write_k(1024);
    send_request(REQ_QUERY, 8'd0, 16'sd8, 16'sd8);
    write_k(2047);
    send_request(REQ_QUERY, 8'd0, 16'sd1, 16'sd1);
  endtask

  task automatic test_large_store();
    write_k(3);
    send_request(REQ_CLEAR, 8'd0, 16'sd0, 16'sd0);
    start <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 30; i++) begin
      send_request(REQ_ADD, 8'($urandom_range(0, 255)), rand_coord(), rand_coord());
    end
    for (int i = 0; i < 3; i++) begin
      send_request(REQ_QUERY, 8'd0, rand_coord(), rand_coord());
    end
    send_request(REQ_CLEAR, 8'd0, 16'sd0, 16'sd0);
  endtask

  task automatic test_random();
    int kind;
    for (int phase = 0; phase < 4; phase++) begin
      write_k(phase == 0 ? 1 : $urandom_range(1, 7));
      send_request(REQ_CLEAR, 8'd0, 16'sd0, 16'sd0);
      for (int i = 0; i < 20; i++) begin
        kind = $urandom_range(0, 19);
        if (kind < 11 && shadow_total < 24)
          send_request(REQ_ADD, 8'($urandom_range(0, 6) == 0 ? $urandom_range(0, 255)
                       : $urandom_range(1, 4)), rand_coord(), rand_coord());
        else if (kind < 18)
          send_request(REQ_QUERY, 8'($urandom_range(0, 255)), rand_coord(), rand_coord());
        else if (kind == 18)
          send_request(REQ_UNUSED, 8'($urandom_range(0, 255)), rand_coord(), rand_coord());
        else
          send_request(REQ_CLEAR, 8'($urandom_range(0, 255)), rand_coord(), rand_coord());
      end
    end
  endtask

  always @(posedge clk) begin
    vote_t want;
    if (!rst && done) begin
      if (pending_votes.size() == 0) begin
        $display("%0t: unexpected result class %0d votes %0d used %0d", $time,
                 winning_class, winning_votes, neighbours_used);
        errors++;
      end else begin
        want = pending_votes.pop_front();
        if (winning_class !== want.cls) begin
          $display("%0t: winning_class expected %0d actual %0d", $time, want.cls,
                   winning_class);
          errors++;
        end
        if (winning_votes !== want.votes) begin
          $display("%0t: winning_votes expected %0d actual %0d", $time, want.votes,
                   winning_votes);
          errors++;
        end
        if (neighbours_used !== want.used) begin
          $display("%0t: neighbours_used expected %0d actual %0d", $time, want.used,
                   neighbours_used);
          errors++;
        end
      end
    end
  end

  // Counts cycles in which no request and no result is accepted.
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[knn_majority_classifier] ERROR");
      $finish;
    end
  end

  initial begin
    errors = 0;
    quiet_cycles = 0;
    shadow_total = 0;
    shadow_k = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_large_store();
    go_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("[knn_majority_classifier] OK");
    else $display("[knn_majority_classifier] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
